/* rtl/core/hdit_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdit_pkg
// Types, codes and constants shared by the hashed device index table.
// ----------------------------------------------------------------------------
package hdit_pkg;

   // Table geometry (depth is a power of two, so the hash reduces by masking)
   localparam int TABLE_DEPTH = 64;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int REQ_SLOT_W  = 8;
   localparam int FOUND_W     = 6;
   localparam int DATA_W      = 64;
   localparam int WORD_W      = 32;

   // Hash mix: seven steps, initial value 0xdeadbeef plus two words times four
   localparam int              MIX_STEPS = 7;
   localparam logic [2:0]      MIX_LAST  = 3'(MIX_STEPS - 1);
   localparam logic [WORD_W-1:0] MIX_INIT = 32'hdeadbeef + 32'd8;

   // Operation codes
   localparam logic [1:0] OP_FIND_FREE = 2'd0;
   localparam logic [1:0] OP_LOOKUP    = 2'd1;
   localparam logic [1:0] OP_READ      = 2'd2;
   localparam logic [1:0] OP_WRITE     = 2'd3;

   // Status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_MISS     = 2'd1;
   localparam logic [1:0] STAT_ZERO_KEY = 2'd2;
   localparam logic [1:0] STAT_RANGE    = 2'd3;

   typedef struct packed {
      logic [1:0]        operation;
      logic [DATA_W-1:0] key;
      logic [REQ_SLOT_W-1:0] slot;
      logic [DATA_W-1:0] entry_value;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FOUND_W-1:0] found_index;
      logic [DATA_W-1:0]  entry_data;
   } rsp_beat_type;

   // Hash unit result
   typedef struct packed {
      logic              done;
      logic [SLOT_W-1:0] pos;
   } mix_result_type;

   // Store access: one address shared by the write and the registered read
   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } store_cmd_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_HASH,
      FSM_PROBE_RD,
      FSM_PROBE_CHK,
      FSM_RD_WAIT,
      FSM_FINISH
   } fsm_state_type;

   // Left rotate by the constant of each mix step
   function automatic logic [WORD_W-1:0] mix_rotl(input logic [2:0] step,
                                                  input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] r;
      case (step)
         3'd0:    r = {v[17:0], v[31:18]};   // 14
         3'd1:    r = {v[20:0], v[31:21]};   // 11
         3'd2:    r = {v[6:0],  v[31:7]};    // 25
         3'd3:    r = {v[15:0], v[31:16]};   // 16
         3'd4:    r = {v[27:0], v[31:28]};   // 4
         3'd5:    r = {v[17:0], v[31:18]};   // 14
         3'd6:    r = {v[7:0],  v[31:8]};    // 24
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/hdit_mix_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdit_mix_unit
// Two-word final mix, one xor/subtract/rotate step per cycle on a shared
// 32-bit datapath. The three words rotate through dst/src/other registers.
// ----------------------------------------------------------------------------
module hdit_mix_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [hdit_pkg::DATA_W-1:0] key,
   output hdit_pkg::mix_result_type    result
);

   logic [hdit_pkg::WORD_W-1:0] dst_ff, dst_in;
   logic [hdit_pkg::WORD_W-1:0] src_ff, src_in;
   logic [hdit_pkg::WORD_W-1:0] oth_ff, oth_in;
   logic [2:0]                  step_ff, step_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [hdit_pkg::SLOT_W-1:0] pos_ff, pos_in;
   logic [hdit_pkg::WORD_W-1:0] mixed;

   // Shared step: dst = (dst ^ src) - rotl(src)
   assign mixed = (dst_ff ^ src_ff) - hdit_pkg::mix_rotl(step_ff, src_ff);

   // Sequencer and word rotation
   always_comb begin
      dst_in  = dst_ff;
      src_in  = src_ff;
      oth_in  = oth_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      pos_in  = pos_ff;
      if (start) begin
         dst_in  = hdit_pkg::MIX_INIT;                               // c
         src_in  = key[63:32] + hdit_pkg::MIX_INIT;                  // b
         oth_in  = key[31:0] + hdit_pkg::MIX_INIT;                   // a
         step_in = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dst_in  = oth_ff;
         src_in  = mixed;
         oth_in  = src_ff;
         step_in = step_ff + 3'd1;
         if (step_ff == hdit_pkg::MIX_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            pos_in  = mixed[hdit_pkg::SLOT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dst_ff  <= dst_in;
      src_ff  <= src_in;
      oth_ff  <= oth_in;
      step_ff <= step_in;
      pos_ff  <= pos_in;
   end

   assign result.done = done_ff;
   assign result.pos  = pos_ff;

endmodule

/* rtl/core/hdit_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdit_store
// Entry memory with registered read and per-entry valid bits; an entry not
// written since reset reads as zero.
// ----------------------------------------------------------------------------
module hdit_store (
   input  logic                        clock,
   input  logic                        reset,
   input  hdit_pkg::store_cmd_type     cmd,
   output logic [hdit_pkg::DATA_W-1:0] rd_data
);

   logic [hdit_pkg::DATA_W-1:0]      mem_ff [hdit_pkg::TABLE_DEPTH];
   logic [hdit_pkg::TABLE_DEPTH-1:0] vld_ff, vld_in;
   logic [hdit_pkg::DATA_W-1:0]      rd_data_ff;
   logic                             rd_vld_ff;

   // Valid bits
   always_comb begin
      vld_in = vld_ff;
      if (cmd.wr_en) begin
         vld_in[cmd.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= vld_ff[cmd.addr];
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.addr] <= cmd.wdata;
      end
      rd_data_ff <= mem_ff[cmd.addr];
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

/* rtl/core/hashed_device_index_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_device_index_table_top
// Open-addressing index table for 64-bit device identifiers with linear
// probing, direct read/write by slot and a configurable lookup mask.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req_      in         req_valid / req_ready  req_data  (req_beat_type)
//  rsp_      out        rsp_valid / rsp_ready  rsp_data  (rsp_beat_type)
//  csr_      in         csr_wr_en              csr_wr_data (info_mask)
//
//  find_free / lookup: hash (7 mix steps on the shared unit plus hand-off),
//  then a registered store read and a check per probe (up to 64 probes),
//  then finish and idle. An in-range read adds a read wait before finish;
//  write, range error and zero key go straight to finish. One beat in flight;
//  a new beat may enter while the last response waits, and finish stalls
//  until the output register is free. Reset clears the valid bits at once.
// ----------------------------------------------------------------------------
module hashed_device_index_table_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  hdit_pkg::req_beat_type      req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output hdit_pkg::rsp_beat_type      rsp_data,
   input  logic                        csr_wr_en,
   input  logic [hdit_pkg::DATA_W-1:0] csr_wr_data
);

   hdit_pkg::fsm_state_type state_ff, state_in;

   logic [hdit_pkg::DATA_W-1:0]  mask_ff, mask_in;
   logic [1:0]                   op_ff, op_in;
   logic [hdit_pkg::DATA_W-1:0]  key_ff, key_in;
   logic [hdit_pkg::SLOT_W-1:0]  pos_ff, pos_in;
   logic [hdit_pkg::SLOT_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]                   res_status_ff, res_status_in;
   logic [hdit_pkg::FOUND_W-1:0] res_found_ff, res_found_in;
   logic [hdit_pkg::DATA_W-1:0]  res_data_ff, res_data_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   hdit_pkg::rsp_beat_type       rsp_data_ff, rsp_data_in;

   hdit_pkg::mix_result_type     mix_res;
   hdit_pkg::store_cmd_type      store_cmd;
   logic [hdit_pkg::DATA_W-1:0]  rd_data;
   logic                         mix_start;
   logic                         accept;
   logic                         in_range;
   logic                         key_zero;
   logic                         hit;
   logic                         last_probe;
   logic                         out_free;

   hdit_mix_unit u_mix (
      .clock  (clock),
      .reset  (reset),
      .start  (mix_start),
      .key    (req_data.key),
      .result (mix_res)
   );

   hdit_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .rd_data (rd_data)
   );

   // Decode helpers
   assign accept     = req_valid && (state_ff == hdit_pkg::FSM_IDLE);
   assign in_range   = 32'(req_data.slot) < hdit_pkg::TABLE_DEPTH;
   assign key_zero   = (req_data.key == '0);
   assign hit        = (op_ff == hdit_pkg::OP_FIND_FREE) ? (rd_data == '0)
                                                         : ((rd_data & mask_ff) == key_ff);
   assign last_probe = (cnt_ff == hdit_pkg::SLOT_W'(hdit_pkg::TABLE_DEPTH - 1));
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hdit_pkg::FSM_IDLE: begin
            if (req_valid) begin
               case (req_data.operation)
                  hdit_pkg::OP_FIND_FREE:
                     state_in = key_zero ? hdit_pkg::FSM_FINISH : hdit_pkg::FSM_HASH;
                  hdit_pkg::OP_LOOKUP:
                     state_in = hdit_pkg::FSM_HASH;
                  hdit_pkg::OP_READ:
                     state_in = in_range ? hdit_pkg::FSM_RD_WAIT : hdit_pkg::FSM_FINISH;
                  default:
                     state_in = hdit_pkg::FSM_FINISH;
               endcase
            end
         end
         hdit_pkg::FSM_HASH: begin
            if (mix_res.done) state_in = hdit_pkg::FSM_PROBE_RD;
         end
         hdit_pkg::FSM_PROBE_RD:  state_in = hdit_pkg::FSM_PROBE_CHK;
         hdit_pkg::FSM_PROBE_CHK: begin
            state_in = (hit || last_probe) ? hdit_pkg::FSM_FINISH : hdit_pkg::FSM_PROBE_RD;
         end
         hdit_pkg::FSM_RD_WAIT:   state_in = hdit_pkg::FSM_FINISH;
         hdit_pkg::FSM_FINISH: begin
            if (out_free) state_in = hdit_pkg::FSM_IDLE;
         end
         default: state_in = hdit_pkg::FSM_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_ready       = (state_ff == hdit_pkg::FSM_IDLE);
      mix_start       = accept && ((req_data.operation == hdit_pkg::OP_LOOKUP) ||
                        ((req_data.operation == hdit_pkg::OP_FIND_FREE) && !key_zero));
      store_cmd.wr_en = accept && (req_data.operation == hdit_pkg::OP_WRITE) && in_range;
      store_cmd.addr  = (state_ff == hdit_pkg::FSM_IDLE) ?
                        req_data.slot[hdit_pkg::SLOT_W-1:0] : pos_ff;
      store_cmd.wdata = req_data.entry_value;
   end

   // Datapath registers
   always_comb begin
      mask_in       = csr_wr_en ? csr_wr_data : mask_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_data_in   = res_data_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         hdit_pkg::FSM_IDLE: begin
            if (req_valid) begin
               op_in         = req_data.operation;
               key_in        = req_data.key;
               res_status_in = hdit_pkg::STAT_OK;
               res_found_in  = '0;
               res_data_in   = '0;
               if ((req_data.operation == hdit_pkg::OP_FIND_FREE) && key_zero) begin
                  res_status_in = hdit_pkg::STAT_ZERO_KEY;
               end else if ((req_data.operation inside {hdit_pkg::OP_READ,
                                                        hdit_pkg::OP_WRITE}) &&
                            !in_range) begin
                  res_status_in = hdit_pkg::STAT_RANGE;
               end
            end
         end
         hdit_pkg::FSM_HASH: begin
            if (mix_res.done) begin
               pos_in = mix_res.pos;
               cnt_in = '0;
            end
         end
         hdit_pkg::FSM_PROBE_CHK: begin
            if (hit) begin
               res_found_in = hdit_pkg::FOUND_W'(pos_ff);
            end else if (last_probe) begin
               res_status_in = hdit_pkg::STAT_MISS;
            end else begin
               // wrap-around step to the next slot
               pos_in = (pos_ff == hdit_pkg::SLOT_W'(hdit_pkg::TABLE_DEPTH - 1)) ?
                        '0 : pos_ff + hdit_pkg::SLOT_W'(1);
               cnt_in = cnt_ff + hdit_pkg::SLOT_W'(1);
            end
         end
         hdit_pkg::FSM_RD_WAIT: begin
            res_data_in = rd_data;
         end
         hdit_pkg::FSM_FINISH: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = res_status_ff;
               rsp_data_in.found_index = res_found_ff;
               rsp_data_in.entry_data  = res_data_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hdit_pkg::FSM_IDLE;
         mask_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_data_ff   <= res_data_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Assertions
   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != hdit_pkg::STAT_OK) |->
         (rsp_data_ff.found_index == '0) && (rsp_data_ff.entry_data == '0))
      else $error("failing response carries non-zero index or data");

   a_hash_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      mix_res.done |-> (state_ff == hdit_pkg::FSM_HASH))
      else $error("hash unit finished outside the hash state");

   a_start_only_idle: assert property (@(posedge clock) disable iff (reset)
      mix_start |=> (state_ff == hdit_pkg::FSM_HASH))
      else $error("hash started without entering the hash state");

   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      store_cmd.wr_en |-> req_ready && $past(state_ff) != hdit_pkg::FSM_PROBE_RD)
      else $error("store write issued while an operation was in progress");

endmodule

/* bench/tb_hashed_device_index_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_device_index_table_top
// Self-checking bench for the hashed device index table. A short directed
// table covers range errors, the zero key and the first writes and reads.
// Random device register, lookup and retire sequences follow under six lookup
// mask settings, mixed with noise beats. The table is filled until full and
// cleared again. Every response is checked field by field against the directed
// expectation or a local model of the hash, the linear probe and the entry store.
// ----------------------------------------------------------------------------
module tb_hashed_device_index_table_top;

   localparam int CLK_HALF        = 5;
   localparam int RESET_CYCLES    = 6;
   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int PHASE_BEATS     = 144;
   localparam int PHASE_COUNT     = 6;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 160;
   localparam int MAX_REPORTS     = 10;
   localparam logic [hdit_pkg::DATA_W-1:0] ALL_ONES = '1;

   typedef struct {
      hdit_pkg::req_beat_type beat;
      bit                     typed;
      hdit_pkg::rsp_beat_type want;
   } stim_row_type;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_ready;
   hdit_pkg::req_beat_type        req_data    = '0;
   logic                          rsp_valid;
   logic                          rsp_ready   = 1'b0;
   hdit_pkg::rsp_beat_type        rsp_data;
   logic                          csr_wr_en   = 1'b0;
   logic [hdit_pkg::DATA_W-1:0]   csr_wr_data = '0;

   // Model state: entry store and lookup mask as the block should hold them
   logic [hdit_pkg::DATA_W-1:0]   entry_shadow [hdit_pkg::TABLE_DEPTH];
   logic [hdit_pkg::DATA_W-1:0]   mask_shadow = ALL_ONES;
   hdit_pkg::rsp_beat_type        awaited_rsp [$];
   stim_row_type                  dir_rows [$];

   int beats_sent;
   int results_seen;
   int mismatches;
   int masks_used;
   int cycle_count;
   int burst_left;
   int hold_off_asks;
   int status_tally [4];

   // Receiver-side pacing
   int hold_left;
   int holds_done;
   int stall_mode;
   int stall_span;
   int rx_tick;

   hashed_device_index_table_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------------
   // Model of the table
   // ---------------------------------------------------------------------
   function automatic logic [hdit_pkg::WORD_W-1:0] rol32(
      input logic [hdit_pkg::WORD_W-1:0] v, input int n);
      return (v << n) | (v >> (hdit_pkg::WORD_W - n));
   endfunction

   // Two-word final mix, seed zero, reduced to the home slot
   function automatic int home_slot(input logic [hdit_pkg::DATA_W-1:0] id);
      logic [hdit_pkg::WORD_W-1:0] a, b, c;
      a = id[31:0] + hdit_pkg::MIX_INIT;
      b = id[63:32] + hdit_pkg::MIX_INIT;
      c = hdit_pkg::MIX_INIT;
      c = (c ^ b) - rol32(b, 14);
      a = (a ^ c) - rol32(c, 11);
      b = (b ^ a) - rol32(a, 25);
      c = (c ^ b) - rol32(b, 16);
      a = (a ^ c) - rol32(c, 4);
      b = (b ^ a) - rol32(a, 14);
      c = (c ^ b) - rol32(b, 24);
      return int'(c % hdit_pkg::TABLE_DEPTH);
   endfunction

   // Linear probe with wrap; -1 when every slot was visited without a hit
   function automatic int probe_slot(input logic [hdit_pkg::DATA_W-1:0] id,
                                     input bit want_free);
      int                          pos;
      logic [hdit_pkg::DATA_W-1:0] e;
      pos = home_slot(id);
      for (int n = 0; n < hdit_pkg::TABLE_DEPTH; n++) begin
         e = entry_shadow[pos];
         if (want_free ? (e == '0) : ((e & mask_shadow) == id))
            return pos;
         pos = (pos + 1) % hdit_pkg::TABLE_DEPTH;
      end
      return -1;
   endfunction

   // Response to one request, updating the store on writes
   function automatic hdit_pkg::rsp_beat_type table_response(
      input hdit_pkg::req_beat_type rq);
      hdit_pkg::rsp_beat_type r;
      int                     where;
      r = '0;
      case (rq.operation)
         hdit_pkg::OP_FIND_FREE: begin
            if (rq.key == '0)
               r.status = hdit_pkg::STAT_ZERO_KEY;
            else begin
               where = probe_slot(rq.key, 1'b1);
               if (where < 0) r.status = hdit_pkg::STAT_MISS;
               else           r.found_index = hdit_pkg::FOUND_W'(where);
            end
         end
         hdit_pkg::OP_LOOKUP: begin
            where = probe_slot(rq.key, 1'b0);
            if (where < 0) r.status = hdit_pkg::STAT_MISS;
            else           r.found_index = hdit_pkg::FOUND_W'(where);
         end
         hdit_pkg::OP_READ: begin
            if (rq.slot < hdit_pkg::TABLE_DEPTH) r.entry_data = entry_shadow[rq.slot];
            else                                 r.status = hdit_pkg::STAT_RANGE;
         end
         default: begin
            if (rq.slot < hdit_pkg::TABLE_DEPTH) entry_shadow[rq.slot] = rq.entry_value;
            else                                 r.status = hdit_pkg::STAT_RANGE;
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   function automatic logic [hdit_pkg::DATA_W-1:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [hdit_pkg::REQ_SLOT_W-1:0] rnd_slot();
      return hdit_pkg::REQ_SLOT_W'($urandom_range(0, 255));
   endfunction

   // Small ids share few home slots, so probes have to walk
   function automatic logic [hdit_pkg::DATA_W-1:0] random_id();
      case ($urandom_range(0, 3))
         0:       return hdit_pkg::DATA_W'($urandom_range(1, 300));
         1:       return {$urandom, 32'h0};
         default: return rnd64();
      endcase
   endfunction

   function automatic void add_row(input logic [1:0] op,
                                   input logic [hdit_pkg::DATA_W-1:0] key,
                                   input logic [hdit_pkg::REQ_SLOT_W-1:0] slot,
                                   input logic [hdit_pkg::DATA_W-1:0] value,
                                   input bit typed, input logic [1:0] status,
                                   input logic [hdit_pkg::DATA_W-1:0] data);
      stim_row_type row;
      row.beat.operation   = op;
      row.beat.key         = key;
      row.beat.slot        = slot;
      row.beat.entry_value = value;
      row.typed            = typed;
      row.want.status      = status;
      row.want.found_index = '0;
      row.want.entry_data  = data;
      dir_rows.push_back(row);
   endfunction

   // Offer one beat, wait for the handshake, then log what should come back
   task automatic send_beat(input hdit_pkg::req_beat_type beat, input bit typed,
                            input hdit_pkg::rsp_beat_type want);
      hdit_pkg::rsp_beat_type got;
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      got = table_response(beat);
      status_tally[got.status]++;
      awaited_rsp.push_back(typed ? want : got);
      beats_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
      end
   endtask

   task automatic send_op(input logic [1:0] op, input logic [hdit_pkg::DATA_W-1:0] key,
                          input logic [hdit_pkg::REQ_SLOT_W-1:0] slot,
                          input logic [hdit_pkg::DATA_W-1:0] value);
      hdit_pkg::req_beat_type beat;
      beat.operation   = op;
      beat.key         = key;
      beat.slot        = slot;
      beat.entry_value = value;
      send_beat(beat, 1'b0, '0);
   endtask

   // Stop offering and wait for every outstanding response
   task automatic wait_drain();
      if (req_valid)
         req_valid <= 1'b0;
      while (awaited_rsp.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_mask(input logic [hdit_pkg::DATA_W-1:0] m);
      csr_wr_data <= m;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      mask_shadow = m;
      csr_wr_en   <= 1'b0;
      masks_used++;
   endtask

   // find_free, store the id in the slot it gave, and often look it up again
   task automatic register_device();
      logic [hdit_pkg::DATA_W-1:0] id, stored;
      int                          free_at;
      id = random_id();
      if (id == '0)
         id = 64'd1;
      send_op(hdit_pkg::OP_FIND_FREE, id, rnd_slot(), rnd64());
      free_at = probe_slot(id, 1'b1);
      if (free_at >= 0) begin
         // bits outside the mask carry per-device info
         stored = (id & mask_shadow) | (rnd64() & ~mask_shadow);
         if (stored == '0)
            stored = id;
         send_op(hdit_pkg::OP_WRITE, rnd64(), hdit_pkg::REQ_SLOT_W'(free_at), stored);
         if ($urandom_range(0, 1))
            send_op(hdit_pkg::OP_LOOKUP, stored & mask_shadow, rnd_slot(), rnd64());
      end
   endtask

   // Pick an occupied slot, maybe find and read it, then empty it
   task automatic retire_device();
      int s;
      s = $urandom_range(0, hdit_pkg::TABLE_DEPTH - 1);
      for (int n = 0; n < hdit_pkg::TABLE_DEPTH && entry_shadow[s] == '0; n++)
         s = (s + 1) % hdit_pkg::TABLE_DEPTH;
      if ($urandom_range(0, 1))
         send_op(hdit_pkg::OP_LOOKUP, entry_shadow[s] & mask_shadow, rnd_slot(), rnd64());
      if ($urandom_range(0, 2) == 0)
         send_op(hdit_pkg::OP_READ, rnd64(), hdit_pkg::REQ_SLOT_W'(s), rnd64());
      send_op(hdit_pkg::OP_WRITE, rnd64(), hdit_pkg::REQ_SLOT_W'(s), '0);
   endtask

   task automatic probe_device();
      int s;
      s = $urandom_range(0, hdit_pkg::TABLE_DEPTH - 1);
      if ($urandom_range(0, 1))
         send_op(hdit_pkg::OP_LOOKUP, entry_shadow[s] & mask_shadow, rnd_slot(), rnd64());
      else
         send_op(hdit_pkg::OP_LOOKUP, random_id(), rnd_slot(), rnd64());
   endtask

   task automatic read_slot();
      logic [hdit_pkg::REQ_SLOT_W-1:0] s;
      if ($urandom_range(0, 3) == 0)
         s = hdit_pkg::REQ_SLOT_W'($urandom_range(hdit_pkg::TABLE_DEPTH, 255));
      else
         s = hdit_pkg::REQ_SLOT_W'($urandom_range(0, hdit_pkg::TABLE_DEPTH - 1));
      send_op(hdit_pkg::OP_READ, rnd64(), s, rnd64());
   endtask

   task automatic noise_beat();
      send_op(2'($urandom_range(0, 3)), ($urandom_range(0, 7) == 0) ? '0 : rnd64(),
              rnd_slot(), rnd64());
   endtask

   task automatic fill_table();
      for (int s = 0; s < hdit_pkg::TABLE_DEPTH; s++)
         send_op(hdit_pkg::OP_WRITE, rnd64(), hdit_pkg::REQ_SLOT_W'(s), rnd64() | 64'h1);
      register_device();
      probe_device();
   endtask

   task automatic clear_table();
      for (int s = 0; s < hdit_pkg::TABLE_DEPTH; s++)
         send_op(hdit_pkg::OP_WRITE, rnd64(), hdit_pkg::REQ_SLOT_W'(s), '0);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [hdit_pkg::DATA_W-1:0] m;
      int                          bias;
      int                          target;
      int                          phase_start;
      int                          pick;
      bit                          held;
      bit                          paused;

      foreach (entry_shadow[i])
         entry_shadow[i] = '0;
      burst_left = $urandom_range(1, 24);
      held       = 1'b0;
      paused     = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: range errors, zero key, empty table, first entries
      add_row(hdit_pkg::OP_READ, '0, 8'd0, '0, 1'b1, hdit_pkg::STAT_OK, '0);
      add_row(hdit_pkg::OP_READ, '0, 8'd63, '0, 1'b1, hdit_pkg::STAT_OK, '0);
      add_row(hdit_pkg::OP_READ, ALL_ONES, 8'd64, ALL_ONES, 1'b1, hdit_pkg::STAT_RANGE, '0);
      add_row(hdit_pkg::OP_READ, '0, 8'd255, '0, 1'b1, hdit_pkg::STAT_RANGE, '0);
      add_row(hdit_pkg::OP_WRITE, '0, 8'd64, ALL_ONES, 1'b1, hdit_pkg::STAT_RANGE, '0);
      add_row(hdit_pkg::OP_WRITE, ALL_ONES, 8'd255, 64'd1, 1'b1, hdit_pkg::STAT_RANGE, '0);
      add_row(hdit_pkg::OP_FIND_FREE, '0, 8'd255, ALL_ONES, 1'b1,
              hdit_pkg::STAT_ZERO_KEY, '0);
      add_row(hdit_pkg::OP_LOOKUP, ALL_ONES, 8'd0, '0, 1'b1, hdit_pkg::STAT_MISS, '0);
      add_row(hdit_pkg::OP_LOOKUP, '0, 8'd0, '0, 1'b0, hdit_pkg::STAT_OK, '0);
      add_row(hdit_pkg::OP_FIND_FREE, ALL_ONES, 8'd0, '0, 1'b0, hdit_pkg::STAT_OK, '0);
      add_row(hdit_pkg::OP_FIND_FREE, 64'd1, 8'd0, '0, 1'b0, hdit_pkg::STAT_OK, '0);
      add_row(hdit_pkg::OP_WRITE, '0, 8'd0, ALL_ONES, 1'b1, hdit_pkg::STAT_OK, '0);
      add_row(hdit_pkg::OP_WRITE, '0, 8'd63, 64'h8000_0000_0000_0001, 1'b1,
              hdit_pkg::STAT_OK, '0);
      add_row(hdit_pkg::OP_READ, '0, 8'd0, '0, 1'b1, hdit_pkg::STAT_OK, ALL_ONES);
      add_row(hdit_pkg::OP_READ, '0, 8'd63, '0, 1'b1, hdit_pkg::STAT_OK,
              64'h8000_0000_0000_0001);
      add_row(hdit_pkg::OP_LOOKUP, ALL_ONES, 8'd0, '0, 1'b0, hdit_pkg::STAT_OK, '0);
      add_row(hdit_pkg::OP_LOOKUP, 64'h8000_0000_0000_0001, 8'd0, '0, 1'b0,
              hdit_pkg::STAT_OK, '0);
      add_row(hdit_pkg::OP_FIND_FREE, ALL_ONES, 8'd0, '0, 1'b0, hdit_pkg::STAT_OK, '0);
      add_row(hdit_pkg::OP_LOOKUP, '0, 8'd0, '0, 1'b0, hdit_pkg::STAT_OK, '0);
      add_row(hdit_pkg::OP_WRITE, '0, 8'd0, '0, 1'b1, hdit_pkg::STAT_OK, '0);
      add_row(hdit_pkg::OP_LOOKUP, ALL_ONES, 8'd0, '0, 1'b1, hdit_pkg::STAT_MISS, '0);
      add_row(hdit_pkg::OP_WRITE, '0, 8'd63, '0, 1'b1, hdit_pkg::STAT_OK, '0);
      add_row(hdit_pkg::OP_READ, '0, 8'd63, '0, 1'b1, hdit_pkg::STAT_OK, '0);
      foreach (dir_rows[i])
         send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

      // Random: one phase per mask setting, alternating fill-heavy and churn-heavy
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0:       m = ALL_ONES;
            1:       m = '0;
            2:       m = 64'h0000_0000_ffff_ffff;
            3:       m = 64'hffff_ffff_0000_0000;
            4:       m = rnd64();
            default: m = ALL_ONES;
         endcase
         wait_drain();
         write_mask(m);
         if (p == 1 || p == 4)
            fill_table();
         else if (p == 2 || p == 5)
            clear_table();

         bias        = (p % 2 == 0) ? 70 : 35;
         phase_start = beats_sent;
         target      = beats_sent + PHASE_BEATS;
         while (beats_sent < target) begin
            // long receiver hold-off while requests keep coming
            if (p == 1 && !held && beats_sent > phase_start + 40) begin
               hold_off_asks++;
               held = 1'b1;
            end
            // one pause mid-phase until every response is back
            if (p == 3 && !paused && beats_sent > phase_start + 90) begin
               wait_drain();
               paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < bias)
               register_device();
            else begin
               case ($urandom_range(0, 5))
                  0, 1:    retire_device();
                  2, 3:    probe_device();
                  4:       read_slot();
                  default: noise_beat();
               endcase
            end
         end
      end

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d request beats under %0d mask settings, %0d responses checked",
               beats_sent, masks_used, results_seen);
      $display("statuses: ok %0d, full/miss %0d, zero key %0d, out of range %0d",
               status_tally[hdit_pkg::STAT_OK], status_tally[hdit_pkg::STAT_MISS],
               status_tally[hdit_pkg::STAT_ZERO_KEY], status_tally[hdit_pkg::STAT_RANGE]);
      if (mismatches == 0 && awaited_rsp.size() == 0)
         $display("tb_hashed_device_index_table_top: PASS");
      else
         $display("tb_hashed_device_index_table_top: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: stall pattern plus an occasional long hold-off
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_done != hold_off_asks) begin
         holds_done = hold_off_asks;
         hold_left  = HOLD_OFF_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 120);
         end
         stall_span--;
         rx_tick++;
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (rx_tick % 3 == 0);
         endcase
      end
   end

   // Compare each response beat with the oldest expectation
   always @(posedge clock) begin
      hdit_pkg::rsp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: status %0d index %0d data %h",
                        rsp_data.status, rsp_data.found_index, rsp_data.entry_data);
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.found_index !== want.found_index ||
                rsp_data.entry_data !== want.entry_data) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("response %0d: want st/idx/data %0d/%0d/%h, got %0d/%0d/%h",
                           results_seen, want.status, want.found_index, want.entry_data,
                           rsp_data.status, rsp_data.found_index, rsp_data.entry_data);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_hashed_device_index_table_top: FAIL");
         $finish;
      end
   end

endmodule

/* filelist.f */
rtl/core/hdit_pkg.sv
rtl/core/hdit_mix_unit.sv
rtl/core/hdit_store.sv
rtl/core/hashed_device_index_table_top.sv
bench/tb_hashed_device_index_table_top.sv
